// ===== rtl/text_console_writer_assert.svh =====
// ---------------------------------------------------------------------------
// text_console_writer_assert.svh
// Assertion macros used by the console writer checker.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Checked only outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// ---------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int SRC_W  = $clog2(2 * CELLS);
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int PADDR_W = 3;

  localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0700;
  localparam logic [7:0]        NEWLINE     = 8'd10;
  localparam logic [7:0]        COLOR_RESET = 8'h07;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SCROLL = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_DRAIN,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  char_in;
    logic [5:0]  scroll_count;
    logic [4:0]  read_row;
    logic [6:0]  read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } tcw_out_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } tcw_wr_t;

endpackage

// ===== rtl/tcw_ram.sv =====
// ---------------------------------------------------------------------------
// tcw_ram
// Screen cell memory, one write port, one registered read port.
// ---------------------------------------------------------------------------
module tcw_ram (
  input  logic                          clk,
  input  tcw_pkg::tcw_wr_t              wr,
  input  logic [tcw_pkg::ADDR_W-1:0]    raddr,
  output logic [tcw_pkg::CELL_W-1:0]    rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tcw_cfg.sv =====
// ---------------------------------------------------------------------------
// tcw_cfg
// APB register file: text attribute byte.
// ---------------------------------------------------------------------------
module tcw_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic [7:0]                  text_color
);
  import tcw_pkg::*;

  logic [7:0] color_r;
  logic [7:0] color_nxt;
  logic       sel_color;

  assign sel_color = (paddr[PADDR_W-1:2] == '0);

  always_comb begin
    color_nxt = color_r;
    if (psel && penable && pwrite && sel_color) begin
      color_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= COLOR_RESET;
    end else begin
      color_r <= color_nxt;
    end
  end

  assign prdata     = sel_color ? {24'd0, color_r} : 32'd0;
  assign text_color = color_r;

endmodule

// ===== rtl/tcw_seq.sv =====
// ---------------------------------------------------------------------------
// tcw_seq
// Command sequencer: cursor, screen sweeps, cell writes and reads, result
// register.
// ---------------------------------------------------------------------------
module tcw_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tcw_pkg::tcw_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tcw_pkg::tcw_out_t           out_data,
  input  logic [7:0]                  text_color,
  output tcw_pkg::tcw_wr_t            mem_wr,
  output logic [tcw_pkg::ADDR_W-1:0]  mem_raddr,
  input  logic [tcw_pkg::CELL_W-1:0]  mem_rdata
);
  import tcw_pkg::*;

  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] LAST_A    = ADDR_W'(CELLS - 1);
  localparam logic [SRC_W-1:0]  CELLS_S   = SRC_W'(CELLS);
  localparam logic [SRC_W-1:0]  COLS_S    = SRC_W'(COLS);
  localparam logic [ROW_W:0]    ROWS_R    = (ROW_W + 1)'(ROWS);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COLS_C    = COL_W'(COLS);
  localparam logic [5:0]        ROWS_CNT  = 6'(ROWS);

  seq_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] p_r, p_nxt;
  logic [SRC_W-1:0]  offs_r, offs_nxt;
  logic              wr_en_r, wr_en_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic              wr_ok_r, wr_ok_nxt;
  logic              init_r, init_nxt;
  logic              char_pend_r, char_pend_nxt;
  logic [ADDR_W-1:0] char_addr_r, char_addr_nxt;
  logic [7:0]        char_byte_r, char_byte_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcw_out_t          out_data_r, out_data_nxt;

  logic [SRC_W-1:0]  src;
  logic              src_ok;
  logic [ROW_W:0]    pc_row;
  logic [COL_W-1:0]  pc_col;
  logic              pc_scroll;
  logic              pc_nl;
  logic [5:0]        scr_n;
  logic              rd_ok;
  logic [ADDR_W-1:0] rd_addr;

  assign src    = SRC_W'(p_r) + offs_r;
  assign src_ok = (src < CELLS_S);

  // cursor update for put_char
  always_comb begin
    pc_nl     = (in_data.char_in == NEWLINE);
    pc_row    = {1'b0, cur_row_r};
    pc_col    = cur_col_r;
    pc_scroll = 1'b0;
    if (pc_nl) begin
      pc_row = pc_row + 1'b1;
      pc_col = '0;
    end
    if (pc_col >= COLS_C) begin
      pc_row = pc_row + 1'b1;
      pc_col = '0;
    end
    if (pc_row >= ROWS_R) begin
      pc_row    = {1'b0, LAST_ROW};
      pc_col    = '0;
      pc_scroll = 1'b1;
    end
  end

  assign scr_n   = (in_data.scroll_count > ROWS_CNT) ? ROWS_CNT : in_data.scroll_count;
  assign rd_ok   = (in_data.read_row < ROW_W'(ROWS)) && (in_data.read_col < COLS_C);
  assign rd_addr = ADDR_W'(in_data.read_row) * COLS_A + ADDR_W'(in_data.read_col);

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    offs_nxt      = offs_r;
    wr_en_nxt     = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    wr_ok_nxt     = wr_ok_r;
    init_nxt      = init_r;
    char_pend_nxt = char_pend_r;
    char_addr_nxt = char_addr_r;
    char_byte_nxt = char_byte_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    cell_nxt      = cell_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_raddr     = src[ADDR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        mem_raddr = rd_addr;
        if (in_valid) begin
          cell_nxt      = '0;
          char_pend_nxt = 1'b0;
          p_nxt         = '0;
          unique case (in_data.command)
            CMD_PUT: begin
              if (in_data.char_in == 8'd0) begin
                state_nxt = ST_DONE;
              end else begin
                char_pend_nxt = !pc_nl;
                char_byte_nxt = in_data.char_in;
                char_addr_nxt = ADDR_W'(pc_row) * COLS_A + ADDR_W'(pc_col);
                cur_row_nxt   = pc_row[ROW_W-1:0];
                cur_col_nxt   = pc_nl ? pc_col : pc_col + 1'b1;
                offs_nxt      = COLS_S;
                if (pc_scroll) begin
                  state_nxt = ST_SWEEP;
                end else if (!pc_nl) begin
                  state_nxt = ST_WRITE;
                end else begin
                  state_nxt = ST_DONE;
                end
              end
            end
            CMD_CLEAR: begin
              offs_nxt  = CELLS_S;
              state_nxt = ST_SWEEP;
            end
            CMD_SCROLL: begin
              offs_nxt  = SRC_W'(scr_n) * COLS_S;
              state_nxt = (scr_n == 6'd0) ? ST_DONE : ST_SWEEP;
            end
            CMD_READ: begin
              state_nxt = rd_ok ? ST_READ : ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        wr_en_nxt   = 1'b1;
        wr_addr_nxt = p_r;
        wr_ok_nxt   = src_ok;
        p_nxt       = p_r + 1'b1;
        if (p_r == LAST_A) begin
          p_nxt     = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (init_r) begin
          init_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else if (char_pend_r) begin
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WRITE: begin
        state_nxt = ST_DONE;
      end
      ST_READ: begin
        cell_nxt  = mem_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.cell_char  = cell_r[7:0];
          out_data_nxt.cell_attr  = cell_r[15:8];
          out_data_nxt.cursor_row = cur_row_r;
          out_data_nxt.cursor_col = cur_col_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_wr.en = wr_en_r || (state_r == ST_WRITE);
    if (state_r == ST_WRITE) begin
      mem_wr.addr = char_addr_r;
      mem_wr.data = {text_color, char_byte_r};
    end else begin
      mem_wr.addr = wr_addr_r;
      mem_wr.data = wr_ok_r ? mem_rdata : BLANK_CELL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      p_r         <= '0;
      offs_r      <= CELLS_S;
      wr_en_r     <= 1'b0;
      init_r      <= 1'b1;
      char_pend_r <= 1'b0;
      cur_row_r   <= LAST_ROW;
      cur_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_r         <= p_nxt;
      offs_r      <= offs_nxt;
      wr_en_r     <= wr_en_nxt;
      init_r      <= init_nxt;
      char_pend_r <= char_pend_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r   <= wr_addr_nxt;
    wr_ok_r     <= wr_ok_nxt;
    char_addr_r <= char_addr_nxt;
    char_byte_r <= char_byte_nxt;
    cell_r      <= cell_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/text_console_writer.sv =====
// ---------------------------------------------------------------------------
// text_console_writer
// 80x25 text console: cell memory, cursor, command sequencer, APB register.
// ---------------------------------------------------------------------------
// The screen lives in one 2000 x 16 memory (attribute high byte, character
// low byte) with one write and one registered read port. After reset the
// block runs a clearing pass with in_stall high; APB writes are taken
// during it. One command is in flight at a time. clear_screen, a nonzero
// scroll_up and a put_char that scrolls sweep the whole memory at one cell
// per cycle through the single write port; a put_char that is not a newline
// then writes its character after the scroll. The result sits in an output
// register, so the next command is taken while it waits.
module text_console_writer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tcw_pkg::tcw_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tcw_pkg::tcw_out_t           out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import tcw_pkg::*;

  logic [7:0]        text_color;
  tcw_wr_t           mem_wr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  assign cfg_pready = 1'b1;

  tcw_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .text_color (text_color)
  );

  tcw_ram u_ram (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcw_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .text_color (text_color),
    .mem_wr     (mem_wr),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

endmodule

// ===== rtl/tcw_checker.sv =====
// ---------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the console writer, bound to the top level.
// ---------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input tcw_pkg::tcw_out_t out_data
);
  import tcw_pkg::*;

  // held result beat stays put
  `TCW_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_data),
    "result beat changed while stalled")

  // clearing pass follows reset
  `TCW_ASSERT_ALWAYS(a_init_busy, !rst_n |=> in_stall, "input taken during clearing pass")

  // one command at a time
  `TCW_ASSERT(a_one_item, in_valid && !in_stall |=> in_stall, "second beat taken back to back")

  // cursor row on screen, column at most one past the last
  `TCW_ASSERT(a_cursor,
    out_valid |-> (out_data.cursor_row < ROW_W'(ROWS)) && (out_data.cursor_col <= COL_W'(COLS)),
    "cursor off screen")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put_char, clear_screen, scroll_up and read_cell beats into the
// console, predicts the screen and cursor after each accepted beat, and checks
// every result beat field by field. It starts with directed cases and a long
// output hold-off. Random text follows, under several idle and stall mixes and
// with the text color changed between phases.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  // Worst case: every beat a full-memory sweep plus long gaps, several times over
  localparam int unsigned CYCLE_LIMIT = 15_000_000;
  localparam logic [PADDR_W-1:0] ADDR_TEXT_COLOR = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  tcw_in_t             in_data     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  tcw_out_t            out_data;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [PADDR_W-1:0]  cfg_paddr   = '0;
  logic [31:0]         cfg_pwdata  = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  // console model
  logic [15:0] screen_mem [CELLS];
  int          cursor_r;
  int          cursor_c;
  logic [7:0]  text_color;

  tcw_out_t    console_view_q[$];
  int          err_count     = 0;
  int          n_checked     = 0;
  int          n_line_scroll = 0;
  int          n_color_set   = 0;
  int          cmd_count[4]  = '{0, 0, 0, 0};
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_left     = 0;

  text_console_writer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d beats still pending",
             CYCLE_LIMIT, console_view_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------- console model ----------------
  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen_mem[i] = BLANK_CELL;
  endfunction

  function automatic void scroll_screen(input int rows);
    int shift;
    if (rows > ROWS) rows = ROWS;
    shift = rows * COLS;
    for (int i = shift; i < CELLS; i++) screen_mem[i - shift] = screen_mem[i];
    for (int i = (ROWS - rows) * COLS; i < CELLS; i++) screen_mem[i] = BLANK_CELL;
  endfunction

  function automatic void print_char(input logic [7:0] ch);
    if (ch == 8'd0) return;
    if (ch == NEWLINE) begin
      cursor_r++;
      cursor_c = 0;
    end
    if (cursor_c >= COLS) begin
      cursor_r++;
      cursor_c = 0;
    end
    if (cursor_r >= ROWS) begin
      cursor_r = ROWS - 1;
      scroll_screen(1);
      cursor_c = 0;
      n_line_scroll++;
    end
    if (ch != NEWLINE) begin
      screen_mem[cursor_r * COLS + cursor_c] = {text_color, ch};
      cursor_c++;
    end
  endfunction

  function automatic tcw_out_t next_console_view(input tcw_in_t d);
    tcw_out_t v;
    int       idx;
    v = '0;
    case (d.command)
      CMD_PUT:    print_char(d.char_in);
      CMD_CLEAR:  blank_screen();
      CMD_SCROLL: scroll_screen(int'(d.scroll_count));
      CMD_READ: begin
        if (int'(d.read_row) < ROWS && int'(d.read_col) < COLS) begin
          idx = int'(d.read_row) * COLS + int'(d.read_col);
          v.cell_char = screen_mem[idx][7:0];
          v.cell_attr = screen_mem[idx][15:8];
        end
      end
      default: ;
    endcase
    v.cursor_row = 5'(cursor_r);
    v.cursor_col = 7'(cursor_c);
    return v;
  endfunction

  // ---------------- result checking ----------------
  task automatic flag_field(input string name, input int unsigned want,
                            input int unsigned seen);
    err_count++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
  endtask

  task automatic check_view(input tcw_out_t got);
    tcw_out_t want;
    if (console_view_q.size() == 0) begin
      err_count++;
      $display("%0t: unexpected result beat %h, expected none", $time, got);
      return;
    end
    want = console_view_q.pop_front();
    n_checked++;
    if (got.cell_char !== want.cell_char)
      flag_field("cell_char", 32'(want.cell_char), 32'(got.cell_char));
    if (got.cell_attr !== want.cell_attr)
      flag_field("cell_attr", 32'(want.cell_attr), 32'(got.cell_attr));
    if (got.cursor_row !== want.cursor_row)
      flag_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
    if (got.cursor_col !== want.cursor_col)
      flag_field("cursor_col", 32'(want.cursor_col), 32'(got.cursor_col));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_view(out_data);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------- drivers ----------------
  task automatic send_beat(input tcw_in_t d);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cmd_count[d.command]++;
    console_view_q.push_back(next_console_view(d));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (console_view_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (wr && addr == ADDR_TEXT_COLOR) begin
      text_color = wdata[7:0];
      n_color_set++;
    end
    @(posedge clk);
  endtask

  task automatic check_color_readback();
    logic [31:0] rd;
    apb_access(1'b0, ADDR_TEXT_COLOR, 32'd0, rd);
    if (rd !== {24'd0, text_color}) begin
      err_count++;
      $display("%0t: text_color readback mismatch, expected %0h, got %0h",
               $time, {24'd0, text_color}, rd);
    end
  endtask

  task automatic set_text_color(input logic [7:0] color);
    logic [31:0] rd;
    wait_idle();
    apb_access(1'b1, ADDR_TEXT_COLOR, {24'($urandom), color}, rd);
    check_color_readback();
  endtask

  function automatic tcw_in_t make_beat(input cmd_t cmd, input logic [7:0] ch,
                                        input logic [5:0] cnt, input logic [4:0] row,
                                        input logic [6:0] col);
    tcw_in_t d;
    d.command      = cmd;
    d.char_in      = ch;
    d.scroll_count = cnt;
    d.read_row     = row;
    d.read_col     = col;
    return d;
  endfunction

  function automatic tcw_in_t rand_beat();
    tcw_in_t d;
    int      pick;
    d.command      = CMD_PUT;
    d.char_in      = 8'($urandom);
    d.scroll_count = 6'($urandom);
    d.read_row     = 5'($urandom);
    d.read_col     = 7'($urandom);
    pick = $urandom_range(99);
    if (pick < 3) begin
      d.char_in = NEWLINE;
    end else if (pick < 5) begin
      d.char_in = 8'd0;
    end else if (pick < 80) begin
      d.command = CMD_PUT;
    end else if (pick < 82) begin
      d.command = CMD_CLEAR;
    end else if (pick < 85) begin
      d.command = CMD_SCROLL;
      if ($urandom_range(1) == 0) d.scroll_count = 6'($urandom_range(3));
    end else begin
      d.command = CMD_READ;
      case ($urandom_range(3))
        0, 1: begin
          d.read_row = 5'(ROWS - 1 - $urandom_range(4));
          d.read_col = 7'($urandom_range(COLS - 1));
        end
        2: begin
          d.read_row = 5'($urandom_range(ROWS - 1));
          d.read_col = 7'($urandom_range(COLS - 1));
        end
        default: ;
      endcase
    end
    return d;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    logic [31:0] rd;
    send_beat(make_beat(CMD_READ, 8'd0, 6'd0, 5'd24, 7'd0));
    send_beat(make_beat(CMD_PUT, 8'h41, 6'd0, 5'd0, 7'd0));
    send_beat(make_beat(CMD_PUT, 8'h00, 6'd0, 5'd0, 7'd0));
    send_beat(make_beat(CMD_PUT, 8'hFF, 6'd0, 5'd0, 7'd0));
    send_beat(make_beat(CMD_READ, 8'd0, 6'd0, 5'd24, 7'd1));
    set_text_color(8'hFF);
    send_beat(make_beat(CMD_PUT, 8'h80, 6'd0, 5'd0, 7'd0));
    send_beat(make_beat(CMD_READ, 8'd0, 6'd0, 5'd24, 7'd2));
    set_text_color(8'h00);
    send_beat(make_beat(CMD_PUT, 8'h01, 6'd0, 5'd0, 7'd0));
    send_beat(make_beat(CMD_READ, 8'd0, 6'd0, 5'd24, 7'd3));
    wait_idle();
    apb_access(1'b1, ADDR_UNMAPPED, 32'hFFFF_FFFF, rd);
    check_color_readback();
    send_beat(make_beat(CMD_PUT, NEWLINE, 6'd0, 5'd0, 7'd0));
    send_beat(make_beat(CMD_READ, 8'd0, 6'd0, 5'd23, 7'd0));
    send_beat(make_beat(CMD_READ, 8'd0, 6'd0, 5'd25, 7'd0));
    send_beat(make_beat(CMD_READ, 8'd0, 6'd0, 5'd31, 7'd127));
    send_beat(make_beat(CMD_READ, 8'd0, 6'd0, 5'd0, 7'd80));
    send_beat(make_beat(CMD_SCROLL, 8'd0, 6'd0, 5'd0, 7'd0));
    send_beat(make_beat(CMD_SCROLL, 8'd0, 6'd1, 5'd0, 7'd0));
    send_beat(make_beat(CMD_READ, 8'd0, 6'd0, 5'd22, 7'd2));
    send_beat(make_beat(CMD_SCROLL, 8'd0, 6'd63, 5'd0, 7'd0));
    send_beat(make_beat(CMD_READ, 8'd0, 6'd0, 5'd22, 7'd2));
    send_beat(make_beat(CMD_PUT, 8'h42, 6'd0, 5'd0, 7'd0));
    send_beat(make_beat(CMD_CLEAR, 8'd0, 6'd0, 5'd0, 7'd0));
    send_beat(make_beat(CMD_READ, 8'd0, 6'd0, 5'd24, 7'd3));
    wait_idle();
  endtask

  task automatic test_output_holdoff();
    tcw_in_t d;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 400;
    for (int i = 0; i < 60; i++) begin
      d = rand_beat();
      if (d.command == CMD_CLEAR || d.command == CMD_SCROLL) d.command = CMD_READ;
      send_beat(d);
    end
    wait_idle();
  endtask

  task automatic test_random_text(input int n, input int idle_pct, input int stall_p);
    set_text_color(8'($urandom));
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    for (int i = 0; i < n; i++) send_beat(rand_beat());
    wait_idle();
  endtask

  initial begin
    blank_screen();
    cursor_r   = ROWS - 1;
    cursor_c   = 0;
    text_color = COLOR_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_output_holdoff();
    test_random_text(467, 0, 0);
    test_random_text(467, 83, 0);
    test_random_text(467, 0, 83);
    test_random_text(467, 7, 7);

    repeat (20) @(posedge clk);
    if (console_view_q.size() != 0) begin
      err_count++;
      $display("%0t: %0d result beats never arrived", $time, console_view_q.size());
    end
    $display("Sent %0d put_char, %0d clear, %0d scroll, %0d read beats; %0d results checked",
             cmd_count[CMD_PUT], cmd_count[CMD_CLEAR], cmd_count[CMD_SCROLL],
             cmd_count[CMD_READ], n_checked);
    $display("%0d line scrolls from printing, %0d text color writes, one long output hold-off",
             n_line_scroll, n_color_set);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
